@@ src/metric_window_threshold_monitor_defines.svh @@
// Assertion macros used by the monitor back end RTL.
`ifndef METRIC_WINDOW_THRESHOLD_MONITOR_DEFINES_SVH
`define METRIC_WINDOW_THRESHOLD_MONITOR_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define MWTM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Antecedent in one cycle implies the consequent in the next.
`define MWTM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/mwtm_pkg.sv @@
// Shared types and constants of the metric window threshold monitor.
`timescale 1ns / 1ps
package mwtm_pkg;

  localparam int VAL_W  = 32;
  localparam int ID_W   = 6;
  localparam int KIND_W = 4;
  localparam int ANUM_W = 5;

  localparam int DEF_MAX_METRICS   = 32;
  localparam int DEF_HISTORY_DEPTH = 8;
  localparam int DEF_MAX_ALERTS    = 16;

  localparam logic [VAL_W-1:0] ALL_ONES = '1;

  // depth of the command queue and of the result queue
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic              req_type;
    logic [ID_W-1:0]   target_id;
    logic [VAL_W-1:0]  sample_value;
    logic [KIND_W-1:0] metric_kind;
    logic [VAL_W-1:0]  warn_level;
    logic [VAL_W-1:0]  crit_level;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [ID_W-1:0]   assigned_id;
    logic [VAL_W-1:0]  window_average;
    logic [VAL_W-1:0]  min_seen;
    logic [VAL_W-1:0]  max_seen;
    logic              alert_valid;
    logic              alert_sev;
    logic [ANUM_W-1:0] alert_number;
    logic [VAL_W-1:0]  alert_limit;
    logic [KIND_W-1:0] alert_kind;
  } rsp_t;

  typedef enum logic {
    OP_UPDATE,
    OP_REGISTER
  } op_e;

  typedef struct packed {
    op_e  op;
    req_t req;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_UPDATE,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_OUT
  } back_state_e;

endpackage

@@ src/mwtm_front.sv @@
// Front end: accepts request words, classifies them and queues them.
`timescale 1ns / 1ps
module mwtm_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  mwtm_pkg::req_t req,
  output logic          cmd_valid,
  input  logic          cmd_take,
  output mwtm_pkg::cmd_t cmd
);

  localparam int PTR_W = (mwtm_pkg::QUEUE_DEPTH > 1) ? $clog2(mwtm_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(mwtm_pkg::QUEUE_DEPTH + 1);

  mwtm_pkg::cmd_t q [mwtm_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;
  mwtm_pkg::cmd_t   cls;

  assign full      = (count == CNT_W'(mwtm_pkg::QUEUE_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = q[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  always_comb begin
    cls.req = req;
    cls.op  = req.req_type ? mwtm_pkg::OP_REGISTER : mwtm_pkg::OP_UPDATE;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(mwtm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(mwtm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ src/mwtm_div.sv @@
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module mwtm_div #(
  parameter int DW = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [mwtm_pkg::VAL_W-1:0] dividend,
  input  logic [DW-1:0]             divisor,
  output logic                      done,
  output logic [mwtm_pkg::VAL_W-1:0] quotient
);

  localparam int STEP_W = $clog2(mwtm_pkg::VAL_W);

  logic                       busy;
  logic [STEP_W-1:0]          step;
  logic [DW-1:0]              rem;
  logic [DW-1:0]              dsr;
  logic [mwtm_pkg::VAL_W-1:0] quo;
  logic [DW:0]                trial;
  logic [DW:0]                diff;
  logic                       fits;

  assign trial    = {rem, quo[mwtm_pkg::VAL_W-1]};
  assign diff     = trial - {1'b0, dsr};
  assign fits     = (trial >= {1'b0, dsr});
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[mwtm_pkg::VAL_W-2:0], fits};
      rem <= fits ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(mwtm_pkg::VAL_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ src/mwtm_back.sv @@
// Back end: slot table, history rings, alert log and result queue.
`timescale 1ns / 1ps
`include "metric_window_threshold_monitor_defines.svh"
module mwtm_back #(
  parameter int MAX_METRICS   = mwtm_pkg::DEF_MAX_METRICS,
  parameter int HISTORY_DEPTH = mwtm_pkg::DEF_HISTORY_DEPTH,
  parameter int MAX_ALERTS    = mwtm_pkg::DEF_MAX_ALERTS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           monitor_enable,
  input  logic           cmd_valid,
  output logic           cmd_take,
  input  mwtm_pkg::cmd_t cmd,
  output logic           empty,
  input  logic           pop,
  output mwtm_pkg::rsp_t rsp
);

  localparam int VAL_W  = mwtm_pkg::VAL_W;
  localparam int ID_W   = mwtm_pkg::ID_W;
  localparam int KIND_W = mwtm_pkg::KIND_W;
  localparam int SLOT_W = (MAX_METRICS > 1) ? $clog2(MAX_METRICS) : 1;
  localparam int USED_W = $clog2(MAX_METRICS + 1);
  localparam int POS_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int ALRT_W = $clog2(MAX_ALERTS + 1);
  localparam int CMPW   = (USED_W > ID_W) ? USED_W : ID_W;
  localparam int HA_W   = SLOT_W + POS_W;
  localparam int OPTR_W = (mwtm_pkg::QUEUE_DEPTH > 1) ? $clog2(mwtm_pkg::QUEUE_DEPTH) : 1;
  localparam int OCNT_W = $clog2(mwtm_pkg::QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [VAL_W-1:0]  warn;
    logic [VAL_W-1:0]  crit;
    logic [VAL_W-1:0]  min;
    logic [VAL_W-1:0]  max;
    logic [POS_W-1:0]  pos;
    logic              full;
  } slot_t;

  mwtm_pkg::back_state_e state, state_next;

  mwtm_pkg::cmd_t   cur;
  mwtm_pkg::rsp_t   rsp_cur;
  logic [USED_W-1:0] slots_used;
  logic [ALRT_W-1:0] alerts_raised;
  logic [mwtm_pkg::ANUM_W-1:0] next_alert_num;

  // slot table and history memories
  slot_t             slot_mem [2**SLOT_W];
  slot_t             slot_rdata;
  slot_t             slot_wdata;
  logic [SLOT_W-1:0] slot_waddr;
  logic              slot_we;
  logic [VAL_W-1:0]  hist_mem [2**HA_W];
  logic [VAL_W-1:0]  hist_rdata;
  logic [HA_W-1:0]   hist_raddr;
  logic              hist_we;

  logic [SLOT_W-1:0] cur_slot;
  logic              table_full;
  logic              id_bad;
  logic [VAL_W-1:0]  val;
  slot_t             upd;
  logic [CNT_W-1:0]  upd_cnt;
  logic              crit_hit;
  logic              warn_hit;
  logic              raise;

  logic [CNT_W-1:0]  win_cnt;
  logic [POS_W-1:0]  sum_idx;
  logic [VAL_W-1:0]  sum;
  logic              div_start;
  logic              div_done;
  logic [VAL_W-1:0]  div_q;

  mwtm_pkg::rsp_t    oq [mwtm_pkg::QUEUE_DEPTH];
  logic [OPTR_W-1:0] owr;
  logic [OPTR_W-1:0] ord;
  logic [OCNT_W-1:0] ocnt;
  logic              oq_full;
  logic              oq_push;
  logic              oq_pop;

  // ---------------- decode and update datapath ----------------
  assign val        = cur.req.sample_value;
  assign cur_slot   = SLOT_W'(CMPW'(cur.req.target_id) - CMPW'(1));
  assign table_full = (slots_used == USED_W'(MAX_METRICS));
  assign id_bad     = !monitor_enable || (cur.req.target_id == '0) ||
                      (CMPW'(cur.req.target_id) > CMPW'(slots_used));
  assign hist_raddr = {cur_slot, sum_idx};

  always_comb begin
    upd      = slot_rdata;
    upd.min  = (val < slot_rdata.min) ? val : slot_rdata.min;
    upd.max  = (val > slot_rdata.max) ? val : slot_rdata.max;
    upd.pos  = (slot_rdata.pos == POS_W'(HISTORY_DEPTH - 1)) ? '0 : slot_rdata.pos + 1'b1;
    upd.full = slot_rdata.full || (upd.pos == '0);
    upd_cnt  = upd.full ? CNT_W'(HISTORY_DEPTH) : CNT_W'(upd.pos);
    crit_hit = (slot_rdata.crit != '0) && (val >= slot_rdata.crit);
    warn_hit = (slot_rdata.warn != '0) && (val >= slot_rdata.warn);
    raise    = (crit_hit || warn_hit) && (alerts_raised < ALRT_W'(MAX_ALERTS));
  end

  always_comb begin
    if (state == mwtm_pkg::ST_DECODE) begin
      slot_waddr      = SLOT_W'(slots_used);
      slot_wdata.kind = cur.req.metric_kind;
      slot_wdata.warn = cur.req.warn_level;
      slot_wdata.crit = cur.req.crit_level;
      slot_wdata.min  = mwtm_pkg::ALL_ONES;
      slot_wdata.max  = '0;
      slot_wdata.pos  = '0;
      slot_wdata.full = 1'b0;
    end else begin
      slot_waddr = cur_slot;
      slot_wdata = upd;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_rdata <= slot_mem[cur_slot];
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[{cur_slot, slot_rdata.pos}] <= val;
    end
    hist_rdata <= hist_mem[hist_raddr];
  end

  mwtm_div #(
    .DW (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (win_cnt),
    .done     (div_done),
    .quotient (div_q)
  );

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mwtm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_take   = 1'b0;
    slot_we    = 1'b0;
    hist_we    = 1'b0;
    div_start  = 1'b0;
    oq_push    = 1'b0;
    case (state)
      mwtm_pkg::ST_IDLE: begin
        cmd_take = cmd_valid;
        if (cmd_valid) begin
          state_next = mwtm_pkg::ST_DECODE;
        end
      end
      mwtm_pkg::ST_DECODE: begin
        if (cur.op == mwtm_pkg::OP_REGISTER) begin
          slot_we    = !table_full;
          state_next = mwtm_pkg::ST_OUT;
        end else if (id_bad) begin
          state_next = mwtm_pkg::ST_OUT;
        end else begin
          state_next = mwtm_pkg::ST_UPDATE;
        end
      end
      mwtm_pkg::ST_UPDATE: begin
        slot_we    = 1'b1;
        hist_we    = 1'b1;
        state_next = mwtm_pkg::ST_SUM_RD;
      end
      mwtm_pkg::ST_SUM_RD: begin
        state_next = mwtm_pkg::ST_SUM_ACC;
      end
      mwtm_pkg::ST_SUM_ACC: begin
        state_next = ((CNT_W'(sum_idx) + 1'b1) == win_cnt) ? mwtm_pkg::ST_DIV_GO
                                                            : mwtm_pkg::ST_SUM_RD;
      end
      mwtm_pkg::ST_DIV_GO: begin
        div_start  = 1'b1;
        state_next = mwtm_pkg::ST_DIV_WAIT;
      end
      mwtm_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = mwtm_pkg::ST_OUT;
        end
      end
      mwtm_pkg::ST_OUT: begin
        oq_push = !oq_full;
        if (!oq_full) begin
          state_next = mwtm_pkg::ST_IDLE;
        end
      end
      default: state_next = mwtm_pkg::ST_IDLE;
    endcase
  end

  // working registers of the item in flight
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cur <= cmd;
    end
    case (state)
      mwtm_pkg::ST_DECODE: begin
        rsp_cur <= '0;
        if (cur.op == mwtm_pkg::OP_REGISTER && !table_full) begin
          rsp_cur.ok          <= 1'b1;
          rsp_cur.assigned_id <= ID_W'(CMPW'(slots_used) + CMPW'(1));
        end
      end
      mwtm_pkg::ST_UPDATE: begin
        rsp_cur.ok       <= 1'b1;
        rsp_cur.min_seen <= upd.min;
        rsp_cur.max_seen <= upd.max;
        if (raise) begin
          rsp_cur.alert_valid  <= 1'b1;
          rsp_cur.alert_sev    <= crit_hit;
          rsp_cur.alert_number <= next_alert_num;
          rsp_cur.alert_limit  <= crit_hit ? slot_rdata.crit : slot_rdata.warn;
          rsp_cur.alert_kind   <= slot_rdata.kind;
        end
        win_cnt <= upd_cnt;
        sum     <= '0;
        sum_idx <= '0;
      end
      mwtm_pkg::ST_SUM_ACC: begin
        sum     <= sum + hist_rdata;
        sum_idx <= sum_idx + 1'b1;
      end
      mwtm_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          rsp_cur.window_average <= div_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_used     <= '0;
      alerts_raised  <= '0;
      next_alert_num <= mwtm_pkg::ANUM_W'(1);
    end else begin
      if (state == mwtm_pkg::ST_DECODE && cur.op == mwtm_pkg::OP_REGISTER && !table_full) begin
        slots_used <= slots_used + 1'b1;
      end
      if (state == mwtm_pkg::ST_UPDATE && raise) begin
        alerts_raised  <= alerts_raised + 1'b1;
        next_alert_num <= next_alert_num + 1'b1;
      end
    end
  end

  // ---------------- result queue ----------------
  assign oq_full = (ocnt == OCNT_W'(mwtm_pkg::QUEUE_DEPTH));
  assign empty   = (ocnt == '0);
  assign rsp     = oq[ord];
  assign oq_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq[owr] <= rsp_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owr  <= '0;
      ord  <= '0;
      ocnt <= '0;
    end else begin
      if (oq_push) begin
        owr <= (owr == OPTR_W'(mwtm_pkg::QUEUE_DEPTH - 1)) ? '0 : owr + 1'b1;
      end
      if (oq_pop) begin
        ord <= (ord == OPTR_W'(mwtm_pkg::QUEUE_DEPTH - 1)) ? '0 : ord + 1'b1;
      end
      case ({oq_push, oq_pop})
        2'b10:   ocnt <= ocnt + 1'b1;
        2'b01:   ocnt <= ocnt - 1'b1;
        default: ocnt <= ocnt;
      endcase
    end
  end

  `MWTM_ASSERT(a_alert_cap, alerts_raised <= ALRT_W'(MAX_ALERTS), "alert log overrun")
  `MWTM_ASSERT(a_slot_cap, slots_used <= USED_W'(MAX_METRICS), "slot table overrun")
  `MWTM_ASSERT(a_fail_clean, (oq_push && !rsp_cur.ok) |-> (rsp_cur.assigned_id == '0 && !rsp_cur.alert_valid), "failed word carries data")
  `MWTM_ASSERT_NEXT(a_div_out, state == mwtm_pkg::ST_DIV_WAIT && div_done, state == mwtm_pkg::ST_OUT, "quotient not delivered")

endmodule

@@ src/metric_window_threshold_monitor.sv @@
// Top level of the metric window threshold monitor.
//
//  channel   | handshake          | word
//  ----------+--------------------+------------------------------------------
//  request   | push / full        | req  (mwtm_pkg::req_t)
//  result    | pop / empty        | rsp  (mwtm_pkg::rsp_t), one per request
//  config    | cfg_valid/cfg_ready| cfg_data = monitor_enable
//
// Register requests and refused updates go from the queue head through
// DECODE to OUT and into the result queue. A successful update also passes
// UPDATE, then SUM_RD and SUM_ACC once per filled history entry (up to
// HISTORY_DEPTH), then DIV_GO and DIV_WAIT; the average comes from a
// 32-step bit-serial divider. One item is in work at a time.
// Reset is synchronous and needs no clearing pass; slot and history memories
// are only read where written. Two-word queues on both sides let the front
// accept while a result waits to be popped.
`timescale 1ns / 1ps
module metric_window_threshold_monitor #(
  parameter int MAX_METRICS   = mwtm_pkg::DEF_MAX_METRICS,
  parameter int HISTORY_DEPTH = mwtm_pkg::DEF_HISTORY_DEPTH,
  parameter int MAX_ALERTS    = mwtm_pkg::DEF_MAX_ALERTS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  mwtm_pkg::req_t req,
  output logic           empty,
  input  logic           pop,
  output mwtm_pkg::rsp_t rsp,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_data
);

  logic           monitor_enable;
  logic           cmd_valid;
  logic           cmd_take;
  mwtm_pkg::cmd_t cmd;

  // config register is always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      monitor_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      monitor_enable <= cfg_data;
    end
  end

  // front: accept and classify into the command queue
  mwtm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd)
  );

  // back: table lookup, history, average, alerts, result queue
  mwtm_back #(
    .MAX_METRICS   (MAX_METRICS),
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .MAX_ALERTS    (MAX_ALERTS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .monitor_enable (monitor_enable),
    .cmd_valid      (cmd_valid),
    .cmd_take       (cmd_take),
    .cmd            (cmd),
    .empty          (empty),
    .pop            (pop),
    .rsp            (rsp)
  );

endmodule
